[design/crpts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpts_pkg
// Shared types and constants of the table seating sampler: beat structs,
// sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package crpts_pkg;

  localparam int U_W      = 16;
  localparam int THETA_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int LABEL_W  = 9;
  localparam int PROD_W   = U_W + COUNT_W;
  localparam int LHS_W    = U_W + COUNT_W + 9;
  localparam int LHS_HI_W = LHS_W - 16;

  localparam logic [THETA_W-1:0] THETA_RESET = 16'd256;
  localparam logic [COUNT_W-1:0] COUNT_SAT   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [U_W-1:0] random_fraction;
    logic           start_run;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] table_label;
    logic               new_table;
    logic [COUNT_W-1:0] table_occupancy;
    logic [LABEL_W-1:0] tables_used;
    logic               overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_CHK_NEW,
    ST_WALK,
    ST_RESULT
  } state_t;

endpackage

[design/crpts_count_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpts_count_mem
// Per-table customer count store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module crpts_count_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [crpts_pkg::COUNT_W-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [crpts_pkg::COUNT_W-1:0] rd_data
);

  logic [crpts_pkg::COUNT_W-1:0] mem_r [DEPTH];
  logic [crpts_pkg::COUNT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/crpts_table_seating_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_table_seating_core
// Chinese Restaurant Process seating: one customer per input beat. Walks the
// cumulative table weights out of the count memory and writes the chosen
// table's updated count back.
//
//   channel | dir | handshake            | beat
//   in_     | in  | in_valid / in_ready  | crpts_pkg::in_t  (draw, restart)
//   out_    | out | out_valid / out_ready| crpts_pkg::out_t (seating result)
//   cfg_    | in  | cfg_valid / cfg_ready| 16-bit theta, Q8.8
//
// After accept the sequencer runs MUL_HI, MUL_LO and CHK_NEW, then walks the
// tables (none when the draw lands on a new table, at most MAX_TABLES),
// then RESULT; the walk reads one count per cycle from the single read port.
// The result sits in an output register; a new beat is taken while it waits.
// A stalled result holds the write-back and the sequencer until out_ready.
// Reset is synchronous; the count memory needs no clearing pass.
// ----------------------------------------------------------------------------
module crp_table_seating_core #(
  parameter int MAX_TABLES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  crpts_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crpts_pkg::out_t                 out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crpts_pkg::THETA_W-1:0]   cfg_data
);

  localparam int AW    = $clog2(MAX_TABLES);
  localparam int TU_W  = $clog2(MAX_TABLES + 1);
  localparam int CUM_W = 41 + AW;
  localparam logic [TU_W-1:0] MAX_TU = TU_W'(MAX_TABLES);

  crpts_pkg::state_t state_r, state_nxt;

  logic [crpts_pkg::THETA_W-1:0]  theta_r;
  logic [crpts_pkg::U_W-1:0]      u_r, u_nxt;
  logic [TU_W-1:0]                tiu_r, tiu_nxt;
  logic [crpts_pkg::COUNT_W-1:0]  cs_r, cs_nxt;
  logic [crpts_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [crpts_pkg::LHS_W-1:0]    lhs_r, lhs_nxt;
  logic [CUM_W-1:0]               cum_r, cum_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic                           pick_new_r, pick_new_nxt;
  logic [crpts_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  crpts_pkg::out_t                out_r, out_nxt;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [crpts_pkg::COUNT_W-1:0]  wr_data;
  logic [crpts_pkg::COUNT_W-1:0]  rd_data;

  logic [crpts_pkg::LHS_HI_W-1:0] lhs_hi;
  logic [CUM_W-1:0]               cum_sum;
  logic                           hit;
  logic                           last;
  logic [TU_W-1:0]                tiu_inc;
  logic [TU_W-1:0]                idx_inc;
  logic [crpts_pkg::COUNT_W-1:0]  cs_inc;
  logic [crpts_pkg::COUNT_W-1:0]  cnt_inc;
  logic                           out_free;

  crpts_count_mem #(
    .DEPTH (MAX_TABLES),
    .AW    (AW)
  ) u_count_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == crpts_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lhs_hi   = lhs_r[crpts_pkg::LHS_W-1:16];
  assign cum_sum  = cum_r + CUM_W'({rd_data, 8'h00});
  assign hit      = CUM_W'(lhs_hi) < cum_sum;
  assign idx_inc  = TU_W'(idx_r) + TU_W'(1);
  assign last     = (idx_inc == tiu_r);
  assign tiu_inc  = tiu_r + TU_W'(1);
  assign cs_inc   = (cs_r == crpts_pkg::COUNT_SAT) ? cs_r : cs_r + 32'd1;
  assign cnt_inc  = (cnt_r == crpts_pkg::COUNT_SAT) ? cnt_r : cnt_r + 32'd1;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crpts_pkg::ST_IDLE;
      theta_r     <= crpts_pkg::THETA_RESET;
      tiu_r       <= '0;
      cs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tiu_r       <= tiu_nxt;
      cs_r        <= cs_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        theta_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    prod_r     <= prod_nxt;
    lhs_r      <= lhs_nxt;
    cum_r      <= cum_nxt;
    idx_r      <= idx_nxt;
    pick_new_r <= pick_new_nxt;
    cnt_r      <= cnt_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    tiu_nxt       = tiu_r;
    cs_nxt        = cs_r;
    prod_nxt      = prod_r;
    lhs_nxt       = lhs_r;
    cum_nxt       = cum_r;
    idx_nxt       = idx_r;
    pick_new_nxt  = pick_new_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = cnt_inc;

    case (state_r)
      crpts_pkg::ST_IDLE: begin
        if (in_valid) begin
          u_nxt = in_data.random_fraction;
          if (in_data.start_run) begin
            tiu_nxt = '0;
            cs_nxt  = '0;
          end
          state_nxt = crpts_pkg::ST_MUL_HI;
        end
      end
      crpts_pkg::ST_MUL_HI: begin
        prod_nxt  = crpts_pkg::PROD_W'(u_r) * crpts_pkg::PROD_W'(cs_r);
        state_nxt = crpts_pkg::ST_MUL_LO;
      end
      crpts_pkg::ST_MUL_LO: begin
        lhs_nxt   = crpts_pkg::LHS_W'({prod_r, 8'h00})
                  + crpts_pkg::LHS_W'(32'(u_r) * 32'(theta_r));
        state_nxt = crpts_pkg::ST_CHK_NEW;
      end
      crpts_pkg::ST_CHK_NEW: begin
        cum_nxt = CUM_W'(theta_r);
        idx_nxt = '0;
        if ((lhs_hi < crpts_pkg::LHS_HI_W'(theta_r)) || (tiu_r == '0)) begin
          pick_new_nxt = 1'b1;
          state_nxt    = crpts_pkg::ST_RESULT;
        end else begin
          pick_new_nxt = 1'b0;
          state_nxt    = crpts_pkg::ST_WALK;
        end
      end
      crpts_pkg::ST_WALK: begin
        if (hit || last) begin
          cnt_nxt   = rd_data;
          state_nxt = crpts_pkg::ST_RESULT;
        end else begin
          cum_nxt = cum_sum;
          idx_nxt = idx_r + AW'(1);
        end
      end
      crpts_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = crpts_pkg::ST_IDLE;
          out_nxt       = '0;
          if (pick_new_r) begin
            if (tiu_r == MAX_TU) begin
              out_nxt.tables_used = crpts_pkg::LABEL_W'(tiu_r);
              out_nxt.overflow    = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = tiu_r[AW-1:0];
              wr_data = 32'd1;
              tiu_nxt = tiu_inc;
              cs_nxt  = cs_inc;
              out_nxt.table_label     = crpts_pkg::LABEL_W'(tiu_inc);
              out_nxt.new_table       = 1'b1;
              out_nxt.table_occupancy = 32'd1;
              out_nxt.tables_used     = crpts_pkg::LABEL_W'(tiu_inc);
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = idx_r;
            wr_data = cnt_inc;
            cs_nxt  = cs_inc;
            out_nxt.table_label     = crpts_pkg::LABEL_W'(idx_inc);
            out_nxt.table_occupancy = cnt_inc;
            out_nxt.tables_used     = crpts_pkg::LABEL_W'(tiu_r);
          end
        end
      end
      default: begin
        state_nxt = crpts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[dv/tb_crp_table_seating_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crp_table_seating_core
// Self-checking bench for the table seating sampler. Seating draws are queued
// by the stimulus process and offered by a clocked driver. A clocked monitor
// predicts each seating at input accept, using its own restaurant state and
// theta, and checks every result beat in order. Phases cover the reset theta,
// theta at both extremes and random values, a fill of every table up to the
// overflow case, random draws with restarts, a long result hold-off and
// random idling on both channels, with a final phase that has none.
// ----------------------------------------------------------------------------
module tb_crp_table_seating_core;

  localparam int SEAT_SLOTS  = 256;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 300;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  crpts_pkg::in_t                in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  crpts_pkg::out_t               out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [crpts_pkg::THETA_W-1:0] cfg_data = '0;

  crp_table_seating_core #(
    .MAX_TABLES(SEAT_SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // restaurant state as predicted
  logic [crpts_pkg::COUNT_W-1:0] seat_count [0:SEAT_SLOTS-1];
  int                            open_tables = 0;
  logic [crpts_pkg::COUNT_W-1:0] seated_total = '0;
  logic [crpts_pkg::THETA_W-1:0] theta_q = crpts_pkg::THETA_RESET;

  crpts_pkg::in_t  pending_draws [$];
  crpts_pkg::out_t owed_seatings [$];
  crpts_pkg::out_t want;

  int   mismatches = 0;
  bit   in_took = 1'b0;
  bit   beat_seen = 1'b0;
  bit   idle_on = 1'b0;
  bit   hold_req = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic crpts_pkg::out_t seat_customer(input crpts_pkg::in_t beat);
    logic [63:0]     weight_sum;
    logic [63:0]     draw_weight;
    logic [63:0]     running;
    int              winner;
    int              used;
    bit              hit;
    crpts_pkg::out_t r;
    r = '0;
    if (beat.start_run) begin
      open_tables  = 0;
      seated_total = '0;
    end
    used        = open_tables;
    weight_sum  = 64'(theta_q) + 64'd256 * 64'(seated_total);
    draw_weight = weight_sum * 64'(beat.random_fraction);
    running     = 64'(theta_q);
    winner      = 0;
    hit         = (draw_weight < (running << 16));
    for (int t = 1; t <= used && !hit; t++) begin
      running = running + 64'd256 * 64'(seat_count[t-1]);
      if (draw_weight < (running << 16)) begin
        winner = t;
        hit    = 1'b1;
      end
    end
    if (!hit) winner = used;
    if (winner == 0) begin
      if (used >= SEAT_SLOTS) begin
        r.tables_used = crpts_pkg::LABEL_W'(used);
        r.overflow    = 1'b1;
        return r;
      end
      seat_count[used] = 32'd1;
      used             = used + 1;
      open_tables      = used;
      if (seated_total != crpts_pkg::COUNT_SAT) seated_total = seated_total + 32'd1;
      r.table_label     = crpts_pkg::LABEL_W'(used);
      r.new_table       = 1'b1;
      r.table_occupancy = 32'd1;
      r.tables_used     = crpts_pkg::LABEL_W'(used);
      return r;
    end
    if (seat_count[winner-1] != crpts_pkg::COUNT_SAT)
      seat_count[winner-1] = seat_count[winner-1] + 32'd1;
    if (seated_total != crpts_pkg::COUNT_SAT) seated_total = seated_total + 32'd1;
    r.table_label     = crpts_pkg::LABEL_W'(winner);
    r.table_occupancy = seat_count[winner-1];
    r.tables_used     = crpts_pkg::LABEL_W'(used);
    return r;
  endfunction

  // monitor: check result beats, predict input beats, track theta
  always @(posedge clk) begin
    in_took   = 1'b0;
    beat_seen = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beat_seen = 1'b1;
        if (owed_seatings.size() == 0) begin
          report_mismatch("result beat with no seating owed");
        end else begin
          want = owed_seatings.pop_front();
          if (out_data.table_label !== want.table_label)
            report_mismatch($sformatf("table_label got %0d want %0d",
                                      out_data.table_label, want.table_label));
          if (out_data.new_table !== want.new_table)
            report_mismatch($sformatf("new_table got %0d want %0d",
                                      out_data.new_table, want.new_table));
          if (out_data.table_occupancy !== want.table_occupancy)
            report_mismatch($sformatf("table_occupancy got %0d want %0d",
                                      out_data.table_occupancy, want.table_occupancy));
          if (out_data.tables_used !== want.tables_used)
            report_mismatch($sformatf("tables_used got %0d want %0d",
                                      out_data.tables_used, want.tables_used));
          if (out_data.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0d want %0d",
                                      out_data.overflow, want.overflow));
        end
      end
      if (in_valid && in_ready) begin
        in_took   = 1'b1;
        beat_seen = 1'b1;
        owed_seatings.push_back(seat_customer(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        beat_seen = 1'b1;
        theta_q   = cfg_data;
      end
    end
  end

  // driver: hold the beat until taken, then idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (in_took && idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_draws.size() > 0) begin
        in_data  <= pending_draws.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 11);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      #1;
      if (beat_seen) quiet = 0;
      else quiet++;
    end
    $display("[crp_table_seating_core] ERROR");
    $finish;
  end

  task automatic queue_draw(input logic [crpts_pkg::U_W-1:0] u, input logic restart);
    crpts_pkg::in_t d;
    d.random_fraction = u;
    d.start_run       = restart;
    pending_draws.push_back(d);
  endtask

  task automatic queue_random(input int n, input int restart_odds);
    logic [crpts_pkg::U_W-1:0] u;
    repeat (n) begin
      case ($urandom_range(0, 15))
        0:       u = '0;
        1:       u = '1;
        default: u = 16'($urandom);
      endcase
      queue_draw(u, restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_draws.size() != 0 || owed_seatings.size() != 0 || in_valid);
  endtask

  task automatic write_theta(input logic [crpts_pkg::THETA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // reset theta: empty restaurant, draw extremes, restart
    queue_draw(16'hFFFF, 1'b0);
    queue_draw(16'h0000, 1'b1);
    queue_draw(16'hFFFF, 1'b0);
    queue_draw(16'h8000, 1'b0);
    queue_draw(16'h0001, 1'b0);
    queue_draw(16'h7FFF, 1'b0);
    queue_draw(16'hFFFE, 1'b0);
    queue_draw(16'h5555, 1'b0);
    queue_draw(16'hAAAA, 1'b0);
    queue_draw(16'h0000, 1'b0);
    queue_draw(16'hFFFF, 1'b1);
    queue_draw(16'h4000, 1'b0);
    drain();

    // smallest theta: new tables rare
    write_theta(16'd1);
    queue_draw(16'h0000, 1'b1);
    queue_draw(16'hFFFF, 1'b0);
    queue_draw(16'hFFFF, 1'b0);
    queue_draw(16'h0001, 1'b0);
    queue_draw(16'h0000, 1'b0);
    queue_draw(16'h8000, 1'b0);
    drain();

    // largest theta: fill every table, overflow, then walk the full room
    write_theta(16'hFFFF);
    queue_draw(16'h0000, 1'b1);
    repeat (SEAT_SLOTS - 1) queue_draw(16'h0000, 1'b0);
    queue_draw(16'h0000, 1'b0);
    queue_draw(16'hFFFF, 1'b0);
    queue_random(20, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_theta(16'd1);
        1:       write_theta(16'hFFFF);
        2:       write_theta(16'($urandom_range(1, 512)));
        4:       write_theta(crpts_pkg::THETA_RESET);
        default: write_theta(16'($urandom_range(1, 65535)));
      endcase
      idle_on = (ph != 2 && ph != 5);
      queue_random(280, 40);
      if (ph == 1) hold_req = 1'b1;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (owed_seatings.size() != 0)
      report_mismatch($sformatf("%0d seatings never returned", owed_seatings.size()));
    if (mismatches == 0) $display("[crp_table_seating_core] OK");
    else $display("[crp_table_seating_core] ERROR");
    $finish;
  end

endmodule

[files.f]
design/crpts_pkg.sv
design/crpts_count_mem.sv
design/crpts_table_seating_core.sv
dv/tb_crp_table_seating_core.sv
